>>> src/nfpa_pkg.sv
package nfpa_pkg;

	localparam int NUM_PORTS   = 256;
	localparam int OFF_W       = 8;
	localparam int RANGE_W     = 9;
	localparam int PORT_W      = 16;
	localparam int GROUP_SIZE  = 16;
	localparam int NUM_GROUPS  = NUM_PORTS / GROUP_SIZE;
	localparam int POS_W       = 4;
	localparam int GRP_IDX_W   = 4;
	localparam int STEP_W      = 3;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLED    = 2'd0,
		CFG_FIRST_PORT = 2'd1,
		CFG_RANGE_SIZE = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		REQ_CLAIM   = 1'b0,
		REQ_RELEASE = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		STATUS_OK          = 2'd0,
		STATUS_NOT_ENABLED = 2'd1,
		STATUS_EXHAUSTED   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_SEARCH,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic capture;
		logic reduce_step;
		logic search;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic enabled;
		logic in_claim;
		logic start_ge_range;
		logic reduce_last;
	} dp_stat_t;

endpackage

>>> src/nfpa_ctrl.sv
module nfpa_ctrl
	import nfpa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (!stat.enabled || !stat.in_claim)
						state_d = ST_FINISH;
					else if (stat.start_ge_range)
						state_d = ST_REDUCE;
					else
						state_d = ST_SEARCH;
				end
			end
			ST_REDUCE: begin
				if (stat.reduce_last)
					state_d = ST_SEARCH;
			end
			ST_SEARCH: state_d = ST_FINISH;
			ST_FINISH: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:   cmd.capture     = in_valid;
			ST_REDUCE: cmd.reduce_step = 1'b1;
			ST_SEARCH: cmd.search      = 1'b1;
			ST_FINISH: cmd.finish      = out_free;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// hold the result until the receiver takes the transaction
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

>>> src/nfpa_dp.sv
module nfpa_dp
	import nfpa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  req_type,
	input  logic [PORT_W-1:0]     port,
	input  dp_cmd_t               cmd,
	output dp_stat_t              stat,
	output logic [1:0]            status,
	output logic [PORT_W-1:0]     claimed_port,
	output logic                  was_reserved
);

	logic                  enabled_q;
	logic [PORT_W-1:0]     first_port_q;
	logic [RANGE_W-1:0]    range_size_q;
	logic [RANGE_W-1:0]    eff_range;

	logic [NUM_PORTS-1:0]  map_q;
	logic [OFF_W-1:0]      search_start_q;

	req_t                  req_q;
	logic [PORT_W-1:0]     port_q;
	logic [OFF_W-1:0]      rem_q;
	logic [STEP_W-1:0]     step_q;
	logic [PORT_W-1:0]     div_sh;

	logic                  any_hi [NUM_GROUPS];
	logic                  any_lo [NUM_GROUPS];
	logic [POS_W-1:0]      pos_hi [NUM_GROUPS];
	logic [POS_W-1:0]      pos_lo [NUM_GROUPS];
	logic                  any_hi_s1 [NUM_GROUPS];
	logic                  any_lo_s1 [NUM_GROUPS];
	logic [POS_W-1:0]      pos_hi_s1 [NUM_GROUPS];
	logic [POS_W-1:0]      pos_lo_s1 [NUM_GROUPS];

	logic                  hit_hi;
	logic                  hit_lo;
	logic [OFF_W-1:0]      idx_hi;
	logic [OFF_W-1:0]      idx_lo;
	logic                  found;
	logic [OFF_W-1:0]      grant_idx;
	logic [RANGE_W-1:0]    grant_nxt;
	logic [OFF_W-1:0]      next_start;

	logic [PORT_W-1:0]     rel_off;
	logic                  rel_hit;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q    <= 1'b0;
			first_port_q <= '0;
			range_size_q <= RANGE_W'(NUM_PORTS);
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_ENABLED:    enabled_q    <= cfg_data[0];
				CFG_FIRST_PORT: first_port_q <= cfg_data;
				CFG_RANGE_SIZE: range_size_q <= cfg_data[RANGE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (range_size_q == '0)
			eff_range = RANGE_W'(1);
		else if (range_size_q > RANGE_W'(NUM_PORTS))
			eff_range = RANGE_W'(NUM_PORTS);
		else
			eff_range = range_size_q;
	end

	// request capture and restoring reduction of the scan start
	assign div_sh = PORT_W'(eff_range) << step_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q  <= req_t'(req_type);
			port_q <= port;
			rem_q  <= search_start_q;
			step_q <= '1;
		end else if (cmd.reduce_step) begin
			if (PORT_W'(rem_q) >= div_sh)
				rem_q <= rem_q - div_sh[OFF_W-1:0];
			step_q <= step_q - STEP_W'(1);
		end
	end

	assign stat.enabled        = enabled_q;
	assign stat.in_claim       = (req_t'(req_type) == REQ_CLAIM);
	assign stat.start_ge_range = ({1'b0, search_start_q} >= eff_range);
	assign stat.reduce_last    = (step_q == '0);

	// first level: per group, first free offset at or after the start and before it
	always_comb begin
		for (int g = 0; g < NUM_GROUPS; g++) begin
			any_hi[g] = 1'b0;
			any_lo[g] = 1'b0;
			pos_hi[g] = '0;
			pos_lo[g] = '0;
			for (int b = GROUP_SIZE - 1; b >= 0; b--) begin
				if (!map_q[g*GROUP_SIZE + b] &&
				    RANGE_W'(g*GROUP_SIZE + b) >= {1'b0, rem_q} &&
				    RANGE_W'(g*GROUP_SIZE + b) < eff_range) begin
					any_hi[g] = 1'b1;
					pos_hi[g] = POS_W'(b);
				end
				if (!map_q[g*GROUP_SIZE + b] &&
				    RANGE_W'(g*GROUP_SIZE + b) < {1'b0, rem_q}) begin
					any_lo[g] = 1'b1;
					pos_lo[g] = POS_W'(b);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.search) begin
			any_hi_s1 <= any_hi;
			any_lo_s1 <= any_lo;
			pos_hi_s1 <= pos_hi;
			pos_lo_s1 <= pos_lo;
		end
	end

	// second level: first group wins, wrap to the part below the start
	always_comb begin
		hit_hi = 1'b0;
		hit_lo = 1'b0;
		idx_hi = '0;
		idx_lo = '0;
		for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
			if (any_hi_s1[g]) begin
				hit_hi = 1'b1;
				idx_hi = {GRP_IDX_W'(g), pos_hi_s1[g]};
			end
			if (any_lo_s1[g]) begin
				hit_lo = 1'b1;
				idx_lo = {GRP_IDX_W'(g), pos_lo_s1[g]};
			end
		end
		found     = hit_hi || hit_lo;
		grant_idx = hit_hi ? idx_hi : idx_lo;
		grant_nxt = {1'b0, grant_idx} + RANGE_W'(1);
		next_start = (grant_nxt >= eff_range) ? '0 : grant_nxt[OFF_W-1:0];
	end

	assign rel_off = port_q - first_port_q;
	assign rel_hit = (rel_off < PORT_W'(eff_range)) && map_q[rel_off[OFF_W-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q          <= '0;
			search_start_q <= '0;
		end else if (cmd.finish && enabled_q) begin
			if (req_q == REQ_CLAIM) begin
				if (found) begin
					map_q[grant_idx] <= 1'b1;
					search_start_q   <= next_start;
				end
			end else if (rel_hit) begin
				map_q[rel_off[OFF_W-1:0]] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status       <= STATUS_OK;
			claimed_port <= '0;
			was_reserved <= 1'b0;
			if (!enabled_q) begin
				status <= STATUS_NOT_ENABLED;
			end else if (req_q == REQ_CLAIM) begin
				if (found)
					claimed_port <= first_port_q + PORT_W'(grant_idx);
				else
					status <= STATUS_EXHAUSTED;
			end else begin
				was_reserved <= rel_hit;
			end
		end
	end

endmodule

>>> src/next_fit_port_allocator_unit.sv
// Next-fit port allocator.
// Input channel (in_valid/in_stall): req_type selects claim or release, port
// gives the port to release. Output channel (out_valid/out_stall) returns one
// result per request: status, claimed_port and was_reserved.
// Configuration channel (cfg_valid/cfg_ready, always ready): index 0 enable,
// 1 first port of the range, 2 range size. Write only while the block is idle.
// Release or disabled request: capture, then finish. Claim: capture, search,
// finish, with reduce steps before search when the stored search start lies
// outside a range that has shrunk (remainder taken one bit per cycle).
// The free-port search runs as a two-level priority tree over the 256-entry
// bitmap, 16 groups of 16, with a register between the levels.
// One request is in flight at a time; the next is taken the cycle after the
// result is registered.
// Reset clears the bitmap, the search start and the configuration
// (disabled, first port 0, range 256).
// A stalled result holds in the output register; the request behind it is
// accepted and worked on, and waits to finish until that transaction is taken.
module next_fit_port_allocator_unit
	import nfpa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  req_type,
	input  logic [PORT_W-1:0]     port,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            status,
	output logic [PORT_W-1:0]     claimed_port,
	output logic                  was_reserved
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	nfpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	nfpa_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.req_type     (req_type),
		.port         (port),
		.cmd          (cmd),
		.stat         (stat),
		.status       (status),
		.claimed_port (claimed_port),
		.was_reserved (was_reserved)
	);

endmodule

>>> verif/tb_next_fit_port_allocator_unit.sv
`timescale 1ns / 100ps

module tb_next_fit_port_allocator_unit
	import nfpa_pkg::*;
;

	localparam int unsigned TIMEOUT_CYCLES = 200000;
	localparam int unsigned SETTLE_CYCLES  = 24;
	localparam int unsigned MAX_REPORTS    = 100;

	typedef struct {
		status_t           status;
		logic [PORT_W-1:0] claimed_port;
		logic              was_reserved;
	} alloc_result_t;

	logic                  clk;
	logic                  arst_n       = 1'b0;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	cfg_reg_t              cfg_index    = CFG_ENABLED;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  in_valid     = 1'b0;
	logic                  in_stall;
	req_t                  req_type     = REQ_CLAIM;
	logic [PORT_W-1:0]     port         = '0;
	logic                  out_valid;
	logic                  out_stall    = 1'b0;
	logic [1:0]            status;
	logic [PORT_W-1:0]     claimed_port;
	logic                  was_reserved;

	// Mirror of the allocator state, owned by the monitor
	bit                    reserved_bits [NUM_PORTS];
	logic [OFF_W-1:0]      scan_origin   = '0;
	logic                  en_mirror     = 1'b0;
	logic [PORT_W-1:0]     base_mirror   = '0;
	logic [RANGE_W-1:0]    size_mirror   = 9'd256;

	alloc_result_t         pending_results [$];
	int unsigned           error_count        = 0;
	int unsigned           cycle_count        = 0;
	int unsigned           sender_idle_pct    = 0;
	int unsigned           receiver_stall_pct = 0;
	int unsigned           hold_len           = 0;
	int unsigned           hold_seq           = 0;
	int unsigned           hold_seen          = 0;
	int unsigned           hold_left          = 0;

	next_fit_port_allocator_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.port         (port),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.claimed_port (claimed_port),
		.was_reserved (was_reserved)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= TIMEOUT_CYCLES);
		$display("tb: failure");
		$finish;
	end

	function automatic int unsigned effective_span(logic [RANGE_W-1:0] size);
		if (size == 0)
			return 1;
		if (size > NUM_PORTS)
			return NUM_PORTS;
		return 32'(size);
	endfunction

	// Next-fit claim or release against the mirrored bitmap
	function automatic alloc_result_t predict_allocation(req_t req, logic [PORT_W-1:0] prt);
		alloc_result_t res;
		int unsigned span;
		int unsigned off;
		int unsigned n;
		bit hit;
		res.status       = STATUS_OK;
		res.claimed_port = '0;
		res.was_reserved = 1'b0;
		span = effective_span(size_mirror);
		hit  = 1'b0;
		if (!en_mirror) begin
			res.status = STATUS_NOT_ENABLED;
		end else if (req == REQ_CLAIM) begin
			off = scan_origin % span;
			for (n = 0; n < span && !hit; n++) begin
				if (!reserved_bits[off])
					hit = 1'b1;
				else
					off = (off + 1 >= span) ? 0 : off + 1;
			end
			if (hit) begin
				reserved_bits[off] = 1'b1;
				res.claimed_port   = base_mirror + PORT_W'(off);
				scan_origin        = (off + 1 >= span) ? '0 : OFF_W'(off + 1);
			end else begin
				res.status = STATUS_EXHAUSTED;
			end
		end else begin
			off = 32'(PORT_W'(prt - base_mirror));
			if (off < span && reserved_bits[off]) begin
				reserved_bits[off] = 1'b0;
				res.was_reserved   = 1'b1;
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(string what);
		if (error_count < MAX_REPORTS)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
		error_count++;
	endtask

	// Monitor: check results first, mirror config writes, then predict newly accepted requests
	always @(posedge clk) begin
		alloc_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result transaction with nothing outstanding");
				end else begin
					want = pending_results.pop_front();
					if (status !== want.status)
						report_mismatch($sformatf("status %0d, want %0d",
							status, want.status));
					if (claimed_port !== want.claimed_port)
						report_mismatch($sformatf("claimed_port %0d, want %0d",
							claimed_port, want.claimed_port));
					if (was_reserved !== want.was_reserved)
						report_mismatch($sformatf("was_reserved %0b, want %0b",
							was_reserved, want.was_reserved));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ENABLED:    en_mirror   = cfg_data[0];
					CFG_FIRST_PORT: base_mirror = cfg_data;
					CFG_RANGE_SIZE: size_mirror = cfg_data[RANGE_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				pending_results.push_back(predict_allocation(req_type, port));
		end
	end

	// Receiver: random stall, or a long hold-off when requested
	always @(negedge clk) begin
		if (hold_seen != hold_seq) begin
			hold_seen <= hold_seq;
			hold_left <= hold_len;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	task automatic send_request(req_t req, logic [PORT_W-1:0] prt);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		port     <= prt;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// Drop valid, wait for every outstanding transaction, then let the block go quiet
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_disabled_requests();
		send_request(REQ_CLAIM, 16'h0000);
		send_request(REQ_RELEASE, 16'h0000);
		settle();
	endtask

	// Range straddling the top of the port space: wrap to port 0, then exhaust
	task automatic test_wrap_and_exhaustion();
		write_reg(CFG_ENABLED, 16'd1);
		write_reg(CFG_FIRST_PORT, 16'hFFFE);
		write_reg(CFG_RANGE_SIZE, 16'd4);
		repeat (5) send_request(REQ_CLAIM, 16'hFFFF);
		send_request(REQ_RELEASE, 16'h0000);
		send_request(REQ_RELEASE, 16'h0000);
		send_request(REQ_RELEASE, 16'h0002);
		send_request(REQ_RELEASE, 16'hFFFD);
		send_request(REQ_CLAIM, 16'h0000);
		settle();
	endtask

	task automatic test_range_bounds();
		// Size zero behaves as a single port
		write_reg(CFG_RANGE_SIZE, 16'd0);
		send_request(REQ_CLAIM, 16'h0000);
		send_request(REQ_RELEASE, 16'hFFFE);
		send_request(REQ_CLAIM, 16'h0000);
		settle();
		// Oversized range saturates at the bitmap size
		write_reg(CFG_FIRST_PORT, 16'h0100);
		write_reg(CFG_RANGE_SIZE, 16'd511);
		repeat (3) send_request(REQ_CLAIM, 16'h0000);
		send_request(REQ_RELEASE, 16'hFFFF);
		send_request(REQ_RELEASE, 16'h0000);
		settle();
		// Shrink so the stored origin lies past the end of the range
		write_reg(CFG_RANGE_SIZE, 16'd3);
		send_request(REQ_CLAIM, 16'h0000);
		send_request(REQ_RELEASE, 16'h0101);
		settle();
	endtask

	// Hold the receiver off while the sender keeps offering, so the input backs up
	task automatic test_backpressure();
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		write_reg(CFG_FIRST_PORT, 16'd5000);
		write_reg(CFG_RANGE_SIZE, 16'd256);
		@(posedge clk);
		hold_len = 300;
		hold_seq++;
		repeat (8) send_request(REQ_CLAIM, 16'h0000);
		repeat (4) send_request(REQ_RELEASE, 16'd5000 + 16'($urandom_range(9)));
		repeat (4) send_request(REQ_CLAIM, 16'h0000);
		settle();
	endtask

	task automatic test_random_phase(int unsigned idle_pct, int unsigned stall_pct,
			int unsigned n_items);
		int unsigned seg;
		int unsigned k;
		int unsigned span;
		logic [PORT_W-1:0] base;
		logic [RANGE_W-1:0] size;
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		for (seg = 0; seg < 5; seg++) begin
			case ($urandom_range(9))
				0:       size = '0;
				1:       size = 9'd256;
				2:       size = RANGE_W'($urandom_range(511, 257));
				3, 4:    size = RANGE_W'($urandom_range(255, 41));
				default: size = RANGE_W'($urandom_range(40, 1));
			endcase
			case ($urandom_range(3))
				0:       base = PORT_W'($urandom_range(65535, 65280));
				1:       base = PORT_W'($urandom_range(255, 0));
				default: base = PORT_W'($urandom());
			endcase
			span = effective_span(size);
			write_reg(CFG_FIRST_PORT, base);
			write_reg(CFG_RANGE_SIZE, CFG_DATA_W'(size));
			write_reg(CFG_ENABLED, CFG_DATA_W'($urandom_range(9) != 0));
			for (k = 0; k < n_items / 5; k++) begin
				if ($urandom_range(99) < 55)
					send_request(REQ_CLAIM, PORT_W'($urandom()));
				else if ($urandom_range(99) < 75)
					send_request(REQ_RELEASE, base + PORT_W'($urandom_range(span + 1)));
				else
					send_request(REQ_RELEASE, PORT_W'($urandom()));
			end
			settle();
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_disabled_requests();
		test_wrap_and_exhaustion();
		test_range_bounds();
		test_backpressure();
		test_random_phase(0, 0, 125);
		test_random_phase(80, 0, 125);
		test_random_phase(0, 80, 125);
		test_random_phase(11, 11, 125);

		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> filelist.f
src/nfpa_pkg.sv
src/nfpa_ctrl.sv
src/nfpa_dp.sv
src/next_fit_port_allocator_unit.sv
verif/tb_next_fit_port_allocator_unit.sv
